// File: src/ll1_predictive_parse_driver_top_defines.svh
// ----------------------------------------------------------------------------
// LL(1) parser assertion macros
// Shared assertion helpers for the predictive parser top level.
// ----------------------------------------------------------------------------
`ifndef LL1_PREDICTIVE_PARSE_DRIVER_TOP_DEFINES_SVH
`define LL1_PREDICTIVE_PARSE_DRIVER_TOP_DEFINES_SVH
`ifndef ASSERT_OFF
`define LL1P_ASSERT(lbl, expr) lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
    (expr)) else $error("ll1p check failed");
`define LL1P_ASSERT_IMP(lbl, ante, cons) lbl: assert property (@(posedge i_clk) \
    disable iff (!i_rst_n) (ante) |-> (cons)) else $error("ll1p check failed");
`else
`define LL1P_ASSERT(lbl, expr)
`define LL1P_ASSERT_IMP(lbl, ante, cons)
`endif
`endif

// File: src/ll1p_pkg.sv
// ----------------------------------------------------------------------------
// LL(1) parser package
// Widths, codes, state and command types shared by the parser modules.
// ----------------------------------------------------------------------------
package ll1p_pkg;

    localparam int SYM_W   = 6;
    localparam int TOK_W   = 5;
    localparam int NT_W    = 5;
    localparam int PROD_W  = 6;
    localparam int POS_W   = 3;
    localparam int LEN_W   = 4;
    localparam int SP_W    = 7;
    localparam int OP_W    = 3;
    localparam int ACT_W   = 3;
    localparam int STEP_W  = 6;
    localparam int TBL_AW  = NT_W + TOK_W;
    localparam int BODY_AW = PROD_W + POS_W;

    localparam logic [LEN_W-1:0]  MAX_BODY       = 4'd8;
    localparam logic [SP_W-1:0]   STACK_DEPTH    = 7'd64;
    localparam logic [STEP_W-1:0] MAX_EXPANSIONS = 6'd32;

    localparam logic [OP_W-1:0] OP_TOKEN = 3'd0;
    localparam logic [OP_W-1:0] OP_TABLE = 3'd1;
    localparam logic [OP_W-1:0] OP_BODY  = 3'd2;
    localparam logic [OP_W-1:0] OP_LEN   = 3'd3;
    localparam logic [OP_W-1:0] OP_START = 3'd4;

    localparam logic [ACT_W-1:0] ACT_EXPAND  = 3'd0;
    localparam logic [ACT_W-1:0] ACT_EPSILON = 3'd1;
    localparam logic [ACT_W-1:0] ACT_MATCH   = 3'd2;
    localparam logic [ACT_W-1:0] ACT_ACCEPT  = 3'd3;
    localparam logic [ACT_W-1:0] ACT_REJECT  = 3'd4;
    localparam logic [ACT_W-1:0] ACT_ACK     = 3'd5;

    typedef enum logic [3:0] {
        S_CLEAR, S_IDLE, S_ACK, S_RD_TOP, S_TOP, S_ROW, S_LEN,
        S_PUSH_RD, S_PUSH_WR, S_MATCH, S_ACCEPT, S_REJECT
    } t_state;

    typedef struct packed {
        logic [OP_W-1:0]   opcode;
        logic [TOK_W-1:0]  token;
        logic [NT_W-1:0]   nonterminal_index;
        logic [PROD_W-1:0] production_index;
        logic [POS_W-1:0]  body_position;
        logic [SYM_W-1:0]  body_symbol;
        logic [LEN_W-1:0]  body_length;
        logic              entry_valid;
    } t_in;

    typedef struct packed {
        logic [ACT_W-1:0]  action;
        logic [NT_W-1:0]   out_nonterminal;
        logic [PROD_W-1:0] out_production;
        logic [TOK_W-1:0]  out_terminal;
        logic              last;
    } t_res;

    typedef struct packed {
        logic             accept;
        logic             clr_step;
        logic             rd_top;
        logic             rd_table;
        logic             rd_len;
        logic             rd_body;
        logic             push_wr;
        logic             start_wr;
        logic             emit;
        logic [ACT_W-1:0] act;
        logic             sp_dec;
        logic             steps_inc;
        logic             cnt_load;
        logic             finish;
    } t_cmd;

    typedef struct packed {
        logic            clear_done;
        logic            out_free;
        logic            finished;
        logic            op_start;
        logic            sp_zero;
        logic            top_end;
        logic            top_term;
        logic            tok_match;
        logic            tok_zero;
        logic            tbl_valid;
        logic            steps_cap;
        logic            len_zero;
        logic            overflow;
        logic            cnt_last;
        logic [SP_W-1:0] sp;
    } t_sts;

endpackage

// File: src/ll1p_in_if.sv
// ----------------------------------------------------------------------------
// LL(1) parser request channel
// Valid/ready channel carrying one input request.
// ----------------------------------------------------------------------------
interface ll1p_in_if;
    logic       valid;
    logic       ready;
    logic [2:0] opcode;
    logic [4:0] token;
    logic [4:0] nonterminal_index;
    logic [5:0] production_index;
    logic [2:0] body_position;
    logic [5:0] body_symbol;
    logic [3:0] body_length;
    logic       entry_valid;

    modport source (
        output valid, opcode, token, nonterminal_index, production_index,
               body_position, body_symbol, body_length, entry_valid,
        input  ready
    );
    modport sink (
        input  valid, opcode, token, nonterminal_index, production_index,
               body_position, body_symbol, body_length, entry_valid,
        output ready
    );
endinterface

// File: src/ll1p_out_if.sv
// ----------------------------------------------------------------------------
// LL(1) parser result channel
// Valid/ready channel carrying one parser action.
// ----------------------------------------------------------------------------
interface ll1p_out_if;
    logic       valid;
    logic       ready;
    logic [2:0] action;
    logic [4:0] out_nonterminal;
    logic [5:0] out_production;
    logic [4:0] out_terminal;
    logic       last;

    modport source (
        output valid, action, out_nonterminal, out_production, out_terminal, last,
        input  ready
    );
    modport sink (
        input  valid, action, out_nonterminal, out_production, out_terminal, last,
        output ready
    );
endinterface

// File: src/ll1p_dp.sv
// ----------------------------------------------------------------------------
// LL(1) parser datapath
// Stack, parse table and production memories with the result register.
// ----------------------------------------------------------------------------
module ll1p_dp
    import ll1p_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_cmd             i_cmd,
    input  t_in              i_in,
    input  logic             i_out_ready,
    input  logic             i_cfg_we,
    input  logic [NT_W-1:0]  i_cfg_data,
    output logic [NT_W-1:0]  o_start,
    output t_sts             o_sts,
    output logic             o_out_valid,
    output t_res             o_out
);

    logic [SYM_W-1:0]  m_stack [64];
    logic [SYM_W:0]    m_table [1024];
    logic [SYM_W-1:0]  m_body  [512];
    logic [LEN_W-1:0]  m_len   [64];

    logic [SYM_W-1:0]  r_stk_q;
    logic [SYM_W:0]    r_tbl_q;
    logic [SYM_W-1:0]  r_body_q;
    logic [LEN_W-1:0]  r_len_q;

    logic [SP_W-1:0]   r_sp;
    logic              r_finished;
    logic [OP_W-1:0]   r_op;
    logic [TOK_W-1:0]  r_tok;
    logic [NT_W-1:0]   r_nt;
    logic [PROD_W-1:0] r_prod;
    logic [LEN_W-1:0]  r_cnt;
    logic [STEP_W-1:0] r_steps;
    logic [TBL_AW-1:0] r_clr;
    logic              r_clear_done;
    logic [NT_W-1:0]   r_start;
    logic              r_out_valid;
    t_res              r_out;

    logic [SP_W-1:0]   w_sp_m1;
    logic [LEN_W-1:0]  w_cnt_m1;
    logic [LEN_W-1:0]  w_len_clip;
    logic              w_stk_we;
    logic [5:0]        w_stk_wa;
    logic [SYM_W-1:0]  w_stk_wd;
    logic              w_tbl_we;
    logic [TBL_AW-1:0] w_tbl_wa;
    logic [SYM_W:0]    w_tbl_wd;
    logic              w_out_free;

    assign w_sp_m1    = r_sp - 7'd1;
    assign w_cnt_m1   = r_cnt - 4'd1;
    assign w_len_clip = (i_in.body_length > MAX_BODY) ? MAX_BODY : i_in.body_length;
    assign w_out_free = !r_out_valid || i_out_ready;

    always_comb begin
        w_stk_we = 1'b0;
        w_stk_wa = '0;
        w_stk_wd = '0;
        if (i_cmd.accept && i_in.opcode == OP_START) begin
            w_stk_we = 1'b1;
        end else if (i_cmd.start_wr) begin
            w_stk_we = 1'b1;
            w_stk_wa = 6'd1;
            w_stk_wd = {1'b1, r_start};
        end else if (i_cmd.push_wr) begin
            w_stk_we = 1'b1;
            w_stk_wa = r_sp[5:0];
            w_stk_wd = r_body_q;
        end
    end

    always_comb begin
        w_tbl_we = 1'b0;
        w_tbl_wa = r_clr;
        w_tbl_wd = '0;
        if (i_cmd.clr_step) begin
            w_tbl_we = 1'b1;
        end else if (i_cmd.accept && i_in.opcode == OP_TABLE) begin
            w_tbl_we = 1'b1;
            w_tbl_wa = {i_in.nonterminal_index, i_in.token};
            w_tbl_wd = {i_in.entry_valid, i_in.entry_valid ? i_in.production_index : 6'd0};
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_stk_we) begin
            m_stack[w_stk_wa] <= w_stk_wd;
        end
        if (i_cmd.rd_top) begin
            r_stk_q <= m_stack[w_sp_m1[5:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_tbl_we) begin
            m_table[w_tbl_wa] <= w_tbl_wd;
        end
        if (i_cmd.rd_table) begin
            r_tbl_q <= m_table[{r_stk_q[NT_W-1:0], r_tok}];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept && i_in.opcode == OP_BODY) begin
            m_body[{i_in.production_index, i_in.body_position}] <= i_in.body_symbol;
        end
        if (i_cmd.rd_body) begin
            r_body_q <= m_body[{r_prod, w_cnt_m1[POS_W-1:0]}];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept && i_in.opcode == OP_LEN) begin
            m_len[i_in.production_index] <= w_len_clip;
        end
        if (i_cmd.rd_len) begin
            r_len_q <= m_len[r_tbl_q[PROD_W-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_op  <= i_in.opcode;
            r_tok <= i_in.token;
        end
        if (i_cmd.rd_table) begin
            r_nt <= r_stk_q[NT_W-1:0];
        end
        if (i_cmd.rd_len) begin
            r_prod <= r_tbl_q[PROD_W-1:0];
        end
        if (i_cmd.cnt_load) begin
            r_cnt <= r_len_q;
        end else if (i_cmd.push_wr) begin
            r_cnt <= w_cnt_m1;
        end
        if (i_cmd.accept) begin
            r_steps <= '0;
        end else if (i_cmd.steps_inc) begin
            r_steps <= r_steps + 6'd1;
        end
        if (i_cmd.emit) begin
            r_out.action          <= i_cmd.act;
            r_out.out_nonterminal <= (i_cmd.act == ACT_EXPAND || i_cmd.act == ACT_EPSILON)
                                     ? r_nt : '0;
            r_out.out_production  <= (i_cmd.act == ACT_EXPAND || i_cmd.act == ACT_EPSILON)
                                     ? r_prod : '0;
            r_out.out_terminal    <= (i_cmd.act == ACT_MATCH) ? r_tok : '0;
            r_out.last            <= !(i_cmd.act == ACT_EXPAND || i_cmd.act == ACT_EPSILON);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sp         <= '0;
            r_finished   <= 1'b1;
            r_clr        <= '0;
            r_clear_done <= 1'b0;
            r_start      <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_start <= i_cfg_data;
            end
            if (i_cmd.clr_step) begin
                r_clr <= r_clr + 10'd1;
                if (&r_clr) begin
                    r_clear_done <= 1'b1;
                end
            end
            if (i_cmd.accept && i_in.opcode == OP_START) begin
                r_sp       <= 7'd2;
                r_finished <= 1'b0;
            end else if (i_cmd.sp_dec) begin
                r_sp <= w_sp_m1;
            end else if (i_cmd.push_wr) begin
                r_sp <= r_sp + 7'd1;
            end
            if (i_cmd.finish) begin
                r_finished <= 1'b1;
            end
            if (i_cmd.emit) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_comb begin
        o_sts.clear_done = r_clear_done;
        o_sts.out_free   = w_out_free;
        o_sts.finished   = r_finished;
        o_sts.op_start   = (r_op == OP_START);
        o_sts.sp_zero    = (r_sp == '0);
        o_sts.top_end    = (r_stk_q == '0);
        o_sts.top_term   = !r_stk_q[SYM_W-1];
        o_sts.tok_match  = (r_stk_q[TOK_W-1:0] == r_tok);
        o_sts.tok_zero   = (r_tok == '0);
        o_sts.tbl_valid  = r_tbl_q[SYM_W];
        o_sts.steps_cap  = (r_steps >= MAX_EXPANSIONS);
        o_sts.len_zero   = (r_len_q == '0);
        o_sts.overflow   = ({1'b0, r_sp} + {4'd0, r_len_q}) > ({1'b0, STACK_DEPTH} + 8'd1);
        o_sts.cnt_last   = (r_cnt == 4'd1);
        o_sts.sp         = r_sp;
    end

    assign o_start     = r_start;
    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

endmodule

// File: src/ll1p_ctrl.sv
// ----------------------------------------------------------------------------
// LL(1) parser controller
// Sequences table clearing, loads, and the expand/match steps of a token.
// ----------------------------------------------------------------------------
module ll1p_ctrl
    import ll1p_pkg::*;
(
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    input  logic [OP_W-1:0] i_in_opcode,
    input  t_sts            i_sts,
    output logic            o_in_ready,
    output t_cmd            o_cmd,
    output t_state          o_state
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_CLEAR: begin
                if (i_sts.clear_done) n_state = S_IDLE;
            end
            S_IDLE: begin
                if (i_in_valid) begin
                    n_state = (i_in_opcode == OP_TOKEN && !i_sts.finished) ? S_RD_TOP : S_ACK;
                end
            end
            S_ACK: begin
                if (i_sts.out_free) n_state = S_IDLE;
            end
            S_RD_TOP: begin
                n_state = i_sts.sp_zero ? S_REJECT : S_TOP;
            end
            S_TOP: begin
                if (i_sts.top_end) begin
                    n_state = i_sts.tok_zero ? S_ACCEPT : S_REJECT;
                end else if (i_sts.top_term) begin
                    n_state = i_sts.tok_match ? S_MATCH : S_REJECT;
                end else begin
                    n_state = S_ROW;
                end
            end
            S_ROW: begin
                n_state = (!i_sts.tbl_valid || i_sts.steps_cap) ? S_REJECT : S_LEN;
            end
            S_LEN: begin
                if (!i_sts.len_zero && i_sts.overflow) begin
                    n_state = S_REJECT;
                end else if (i_sts.out_free) begin
                    n_state = i_sts.len_zero ? S_RD_TOP : S_PUSH_RD;
                end
            end
            S_PUSH_RD: begin
                n_state = S_PUSH_WR;
            end
            S_PUSH_WR: begin
                n_state = i_sts.cnt_last ? S_RD_TOP : S_PUSH_RD;
            end
            S_MATCH, S_ACCEPT, S_REJECT: begin
                if (i_sts.out_free) n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        o_cmd      = '0;
        o_in_ready = 1'b0;
        case (r_state)
            S_CLEAR: begin
                o_cmd.clr_step = !i_sts.clear_done;
            end
            S_IDLE: begin
                o_in_ready   = 1'b1;
                o_cmd.accept = i_in_valid;
            end
            S_ACK: begin
                o_cmd.start_wr = i_sts.op_start;
                o_cmd.emit     = i_sts.out_free;
                o_cmd.act      = ACT_ACK;
            end
            S_RD_TOP: begin
                o_cmd.rd_top = !i_sts.sp_zero;
            end
            S_TOP: begin
                o_cmd.rd_table = !i_sts.top_end && !i_sts.top_term;
            end
            S_ROW: begin
                o_cmd.rd_len = i_sts.tbl_valid && !i_sts.steps_cap;
            end
            S_LEN: begin
                if (!(!i_sts.len_zero && i_sts.overflow) && i_sts.out_free) begin
                    o_cmd.emit      = 1'b1;
                    o_cmd.act       = i_sts.len_zero ? ACT_EPSILON : ACT_EXPAND;
                    o_cmd.sp_dec    = 1'b1;
                    o_cmd.steps_inc = 1'b1;
                    o_cmd.cnt_load  = 1'b1;
                end
            end
            S_PUSH_RD: begin
                o_cmd.rd_body = 1'b1;
            end
            S_PUSH_WR: begin
                o_cmd.push_wr = 1'b1;
            end
            S_MATCH: begin
                o_cmd.emit   = i_sts.out_free;
                o_cmd.act    = ACT_MATCH;
                o_cmd.sp_dec = i_sts.out_free;
            end
            S_ACCEPT: begin
                o_cmd.emit   = i_sts.out_free;
                o_cmd.act    = ACT_ACCEPT;
                o_cmd.sp_dec = i_sts.out_free;
                o_cmd.finish = i_sts.out_free;
            end
            S_REJECT: begin
                o_cmd.emit   = i_sts.out_free;
                o_cmd.act    = ACT_REJECT;
                o_cmd.finish = i_sts.out_free;
            end
            default: begin
                o_cmd = '0;
            end
        endcase
    end

    assign o_state = r_state;

endmodule

// File: src/ll1_predictive_parse_driver_top.sv
// Load, start and ignored token requests are each answered with an acknowledge.
// A token first reads the stack top; a match or accept then emits its result, while an
// expansion reads the table row and body length, then reads and pushes each body symbol.
// One request is processed at a time; the next is taken once the last result is registered.
// After reset a clearing pass empties all 1024 parse table entries; no request
// is taken during it, configuration writes are.
// ----------------------------------------------------------------------------
// LL(1) predictive parser top level
// Table-driven predictive parser with request/result channels and an APB port.
// ----------------------------------------------------------------------------
`include "ll1_predictive_parse_driver_top_defines.svh"
module ll1_predictive_parse_driver_top
    import ll1p_pkg::*;
(
    input  logic          i_clk,
    input  logic          i_rst_n,
    ll1p_in_if.sink       i_in,
    ll1p_out_if.source    o_out,
    input  logic          psel,
    input  logic          penable,
    input  logic          pwrite,
    input  logic [1:0]    paddr,
    input  logic [31:0]   pwdata,
    output logic [31:0]   prdata,
    output logic          pready
);

    t_cmd            w_cmd;
    t_sts            w_sts;
    t_state          w_state;
    t_in             w_in;
    t_res            w_res;
    logic            w_out_valid;
    logic            w_cfg_we;
    logic [NT_W-1:0] w_start;

    assign pready   = 1'b1;
    assign w_cfg_we = psel && penable && pwrite && pready && (paddr == 2'd0);
    assign prdata   = {27'd0, w_start};

    assign w_in.opcode            = i_in.opcode;
    assign w_in.token             = i_in.token;
    assign w_in.nonterminal_index = i_in.nonterminal_index;
    assign w_in.production_index  = i_in.production_index;
    assign w_in.body_position     = i_in.body_position;
    assign w_in.body_symbol       = i_in.body_symbol;
    assign w_in.body_length       = i_in.body_length;
    assign w_in.entry_valid       = i_in.entry_valid;

    ll1p_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .i_in_opcode (i_in.opcode),
        .i_sts       (w_sts),
        .o_in_ready  (i_in.ready),
        .o_cmd       (w_cmd),
        .o_state     (w_state)
    );

    ll1p_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .i_in        (w_in),
        .i_out_ready (o_out.ready),
        .i_cfg_we    (w_cfg_we),
        .i_cfg_data  (pwdata[NT_W-1:0]),
        .o_start     (w_start),
        .o_sts       (w_sts),
        .o_out_valid (w_out_valid),
        .o_out       (w_res)
    );

    assign o_out.valid           = w_out_valid;
    assign o_out.action          = w_res.action;
    assign o_out.out_nonterminal = w_res.out_nonterminal;
    assign o_out.out_production  = w_res.out_production;
    assign o_out.out_terminal    = w_res.out_terminal;
    assign o_out.last            = w_res.last;

    `LL1P_ASSERT(a_sp_bound, w_sts.sp <= STACK_DEPTH)
    `LL1P_ASSERT_IMP(a_mid_step, o_out.valid && !o_out.last, o_out.action <= ACT_EPSILON)
    `LL1P_ASSERT_IMP(a_clear_blocks, w_state == S_CLEAR, !i_in.ready)

endmodule

// File: bench/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// LL(1) predictive parser testbench
// Loads random grammars and feeds parse sessions built from tokens that the
// grammar mostly accepts. Every parser action is checked against a model.
// Bursty requests, a stalling result side and start-symbol changes between
// phases are covered.
// ----------------------------------------------------------------------------
module tb_top;
    import ll1p_pkg::*;

    localparam int WATCHDOG_LIMIT = 20000;
    localparam int DRAIN_CYCLES   = 40;
    localparam int ITEM_TARGET    = 430;

    typedef struct {
        logic [5:0]  stk [64];
        int unsigned sp;
        logic        tv [1024];
        logic [5:0]  tp [1024];
        logic [5:0]  bs [512];
        logic [3:0]  bl [64];
        bit          done;
        logic [4:0]  start_nt;
    } t_parser;

    logic        i_clk;
    logic        i_rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [1:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    ll1p_in_if  req_if ();
    ll1p_out_if act_if ();

    ll1_predictive_parse_driver_top DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (req_if),
        .o_out   (act_if),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    t_parser dut_view;
    t_parser plan_view;
    t_in     request_queue [$];
    t_res    expected_actions [$];
    bit      prod_defined [64];
    int      errors;
    int      idle_cycles;
    bit      req_taken;
    bit      long_hold_req;
    bit      sender_pause;

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    function automatic void queue_action(ref t_res q [$], input t_res a);
        q.insert(q.size(), a);
    endfunction

    function automatic void reset_parser(ref t_parser s);
        for (int i = 0; i < 64; i++) begin
            s.stk[i] = '0;
            s.bl[i]  = '0;
        end
        for (int i = 0; i < 1024; i++) begin
            s.tv[i] = 1'b0;
            s.tp[i] = '0;
        end
        for (int i = 0; i < 512; i++) s.bs[i] = '0;
        s.sp       = 0;
        s.done     = 1'b1;
        s.start_nt = '0;
    endfunction

    function automatic t_res make_action(logic [2:0] act, logic [4:0] nt, logic [5:0] prod,
                                         logic [4:0] term, logic last);
        t_res a;
        a.action          = act;
        a.out_nonterminal = nt;
        a.out_production  = prod;
        a.out_terminal    = term;
        a.last            = last;
        return a;
    endfunction

    function automatic void parse_request(ref t_parser s, input t_in r, ref t_res acts [$]);
        logic [5:0]  top;
        logic [4:0]  nt;
        logic [9:0]  tidx;
        logic [5:0]  prod;
        int unsigned len;
        int unsigned steps;
        acts.delete();
        if (r.opcode == OP_TOKEN && !s.done) begin
            steps = 0;
            forever begin
                if (s.sp == 0) begin
                    s.done = 1'b1;
                    queue_action(acts, make_action(ACT_REJECT, '0, '0, '0, 1'b1));
                    return;
                end
                top = s.stk[s.sp-1];
                if (top == 0 || top < 32) begin
                    if (top[4:0] != r.token) begin
                        s.done = 1'b1;
                        queue_action(acts, make_action(ACT_REJECT, '0, '0, '0, 1'b1));
                    end else if (top == 0) begin
                        s.sp--;
                        s.done = 1'b1;
                        queue_action(acts, make_action(ACT_ACCEPT, '0, '0, '0, 1'b1));
                    end else begin
                        s.sp--;
                        queue_action(acts, make_action(ACT_MATCH, '0, '0, r.token, 1'b1));
                    end
                    return;
                end
                nt   = top[4:0];
                tidx = {nt, r.token};
                prod = s.tp[tidx];
                if (!s.tv[tidx] || steps >= 32) begin
                    s.done = 1'b1;
                    queue_action(acts, make_action(ACT_REJECT, '0, '0, '0, 1'b1));
                    return;
                end
                len = s.bl[prod];
                s.sp--;
                if (len == 0) begin
                    queue_action(acts, make_action(ACT_EPSILON, nt, prod, '0, 1'b0));
                end else if (s.sp + len > 64) begin
                    s.done = 1'b1;
                    queue_action(acts, make_action(ACT_REJECT, '0, '0, '0, 1'b1));
                    return;
                end else begin
                    for (int i = len; i > 0; i--) begin
                        s.stk[s.sp] = s.bs[{prod, 3'(i-1)}];
                        s.sp++;
                    end
                    queue_action(acts, make_action(ACT_EXPAND, nt, prod, '0, 1'b0));
                end
                steps++;
            end
        end
        case (r.opcode)
            OP_TABLE: begin
                s.tv[{r.nonterminal_index, r.token}] = r.entry_valid;
                s.tp[{r.nonterminal_index, r.token}] = r.entry_valid ? r.production_index : '0;
            end
            OP_BODY:  s.bs[{r.production_index, r.body_position}] = r.body_symbol;
            OP_LEN:   s.bl[r.production_index] = (r.body_length > 8) ? 4'd8 : r.body_length;
            OP_START: begin
                s.stk[0] = '0;
                s.stk[1] = {1'b1, s.start_nt};
                s.sp     = 2;
                s.done   = 1'b0;
            end
            default: ;
        endcase
        queue_action(acts, make_action(ACT_ACK, '0, '0, '0, 1'b1));
    endfunction

    function automatic t_in rand_req(logic [2:0] op);
        t_in r;
        r.opcode            = op;
        r.token             = 5'($urandom);
        r.nonterminal_index = 5'($urandom);
        r.production_index  = 6'($urandom);
        r.body_position     = 3'($urandom);
        r.body_symbol       = 6'($urandom);
        r.body_length       = 4'($urandom);
        r.entry_valid       = 1'($urandom);
        return r;
    endfunction

    function automatic void add_req(t_in r);
        t_res scratch [$];
        request_queue.insert(request_queue.size(), r);
        parse_request(plan_view, r, scratch);
    endfunction

    function automatic void add_token(logic [4:0] tok);
        t_in r;
        r       = rand_req(OP_TOKEN);
        r.token = tok;
        add_req(r);
    endfunction

    function automatic void add_table(logic [4:0] nt, logic [4:0] tok, logic [5:0] prod,
                                      logic valid);
        t_in r;
        r                   = rand_req(OP_TABLE);
        r.nonterminal_index = nt;
        r.token             = tok;
        r.production_index  = prod;
        r.entry_valid       = valid;
        add_req(r);
    endfunction

    function automatic void define_production(logic [5:0] prod, logic [3:0] len,
                                              logic [5:0] syms [8]);
        t_in r;
        for (int i = 0; i < ((len > 8) ? 8 : len); i++) begin
            r                  = rand_req(OP_BODY);
            r.production_index = prod;
            r.body_position    = 3'(i);
            r.body_symbol      = syms[i];
            add_req(r);
        end
        r                  = rand_req(OP_LEN);
        r.production_index = prod;
        r.body_length      = len;
        add_req(r);
        prod_defined[prod] = 1'b1;
    endfunction

    function automatic logic [4:0] choose_token();
        t_parser    trial;
        t_in        probe;
        t_res       acts [$];
        logic [4:0] good [$];
        for (int t = 0; t < 32; t++) begin
            trial       = plan_view;
            probe       = rand_req(OP_TOKEN);
            probe.token = 5'(t);
            parse_request(trial, probe, acts);
            if (acts[acts.size()-1].action != ACT_REJECT) good.insert(good.size(), 5'(t));
        end
        if (good.size() != 0 && $urandom_range(0, 99) < 85)
            return good[$urandom_range(0, good.size()-1)];
        return 5'($urandom_range(0, 31));
    endfunction

    task automatic reg_write(logic [4:0] value);
        @(negedge i_clk);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b1;
        paddr   = 2'd0;
        pwdata  = {27'd0, value};
        @(negedge i_clk);
        penable = 1'b1;
        @(negedge i_clk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
        dut_view.start_nt  = value;
        plan_view.start_nt = value;
    endtask

    task automatic wait_idle();
        while (request_queue.size() != 0 || expected_actions.size() != 0 || req_if.valid)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic build_grammar(ref int added);
        logic [4:0] nts [5];
        logic [4:0] terms [4];
        logic [5:0] prods [8];
        logic [5:0] syms [8];
        logic [3:0] len;
        nts[0] = plan_view.start_nt;
        for (int i = 1; i < 5; i++) nts[i] = 5'($urandom_range(0, 31));
        for (int i = 0; i < 4; i++) terms[i] = 5'($urandom_range(1, 31));
        for (int p = 0; p < 8; p++) begin
            prods[p] = 6'($urandom_range(0, 63));
            len = ($urandom_range(0, 9) == 0) ? 4'($urandom_range(8, 15))
                                              : 4'($urandom_range(0, 3));
            for (int i = 0; i < 8; i++)
                syms[i] = ($urandom_range(0, 9) < 6) ? {1'b0, terms[$urandom_range(0, 3)]}
                                                     : {1'b1, nts[$urandom_range(0, 4)]};
            define_production(prods[p], len, syms);
            added += ((len > 8) ? 8 : len) + 1;
        end
        for (int n = 0; n < 5; n++) begin
            for (int t = 0; t < 5; t++) begin
                if ($urandom_range(0, 9) < 7) begin
                    add_table(nts[n], (t == 4) ? 5'd0 : terms[t], prods[$urandom_range(0, 7)],
                              1'b1);
                    added++;
                end
            end
        end
    endtask

    task automatic run_sessions(int quota, ref int added);
        t_in r;
        int  n;
        int  p;
        while (quota > 0) begin
            add_req(rand_req(OP_START));
            quota--;
            added++;
            n = $urandom_range(1, 14);
            while (n > 0 && !plan_view.done) begin
                add_token(choose_token());
                n--;
                quota--;
                added++;
                if ($urandom_range(0, 99) < 12) begin
                    case ($urandom_range(0, 3))
                        0: add_table(5'($urandom), 5'($urandom), 6'd0, 1'b0);
                        1: add_req(rand_req(OP_BODY));
                        2: add_req(rand_req(3'($urandom_range(5, 7))));
                        default: begin
                            p = $urandom_range(0, 63);
                            if (prod_defined[p]) begin
                                add_table(5'($urandom), 5'($urandom), 6'(p), 1'b1);
                            end else begin
                                r = rand_req(OP_TABLE);
                                r.entry_valid = 1'b0;
                                add_req(r);
                            end
                        end
                    endcase
                    quota--;
                    added++;
                end
            end
            if ($urandom_range(0, 4) == 0) begin
                add_token(5'($urandom));
                added++;
            end
        end
    endtask

    task automatic directed_part();
        logic [5:0] syms [8];
        add_token(5'd1);
        add_req(rand_req(3'd5));
        add_req(rand_req(3'd7));
        syms = '{6'd1, 6'd33, 6'd0, 6'd0, 6'd0, 6'd0, 6'd0, 6'd0};
        define_production(6'd0, 4'd2, syms);
        define_production(6'd1, 4'd0, syms);
        syms = '{default: 6'd34};
        define_production(6'd2, 4'd15, syms);
        syms = '{default: 6'd35};
        define_production(6'd3, 4'd1, syms);
        syms = '{default: 6'd34};
        define_production(6'd4, 4'd1, syms);
        syms = '{default: 6'd2};
        define_production(6'd63, 4'd1, syms);
        add_table(5'd0, 5'd1, 6'd0, 1'b1);
        add_table(5'd1, 5'd0, 6'd1, 1'b1);
        add_table(5'd1, 5'd8, 6'd1, 1'b1);
        add_table(5'd0, 5'd5, 6'd4, 1'b1);
        add_table(5'd2, 5'd5, 6'd2, 1'b1);
        add_table(5'd0, 5'd6, 6'd3, 1'b1);
        add_table(5'd3, 5'd6, 6'd3, 1'b1);
        add_table(5'd0, 5'd7, 6'd63, 1'b1);
        add_table(5'd31, 5'd31, 6'd0, 1'b0);
        // Clean accept, then a token after the accept.
        add_req(rand_req(OP_START));
        add_token(5'd1);
        add_token(5'd0);
        add_token(5'd3);
        // Empty entry, terminal mismatch, end marker mismatch.
        add_req(rand_req(OP_START));
        add_token(5'd9);
        add_req(rand_req(OP_START));
        add_token(5'd7);
        add_req(rand_req(OP_START));
        add_token(5'd1);
        add_token(5'd8);
        // Stack overflow and the expansion cap.
        add_req(rand_req(OP_START));
        add_token(5'd5);
        add_req(rand_req(OP_START));
        add_token(5'd6);
    endtask

    always @(negedge i_clk) begin : sender
        static int burst_left = 0;
        static int gap_left   = 0;
        t_in r;
        if (!i_rst_n) begin
            req_if.valid <= 1'b0;
        end else if (!req_if.valid || req_taken) begin
            req_taken = 1'b0;
            if (gap_left > 0) gap_left--;
            if (request_queue.size() != 0 && gap_left == 0 && !sender_pause) begin
                r = request_queue[0];
                req_if.valid             <= 1'b1;
                req_if.opcode            <= r.opcode;
                req_if.token             <= r.token;
                req_if.nonterminal_index <= r.nonterminal_index;
                req_if.production_index  <= r.production_index;
                req_if.body_position     <= r.body_position;
                req_if.body_symbol       <= r.body_symbol;
                req_if.body_length       <= r.body_length;
                req_if.entry_valid       <= r.entry_valid;
                if (burst_left > 0) begin
                    burst_left--;
                end else begin
                    burst_left = $urandom_range(1, 16);
                    gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
                end
            end else begin
                req_if.valid <= 1'b0;
            end
        end
    end

    always @(negedge i_clk) begin : receiver
        static int hold_left    = 0;
        static int stretch_left = 0;
        static bit choppy       = 1'b0;
        if (!i_rst_n) begin
            act_if.ready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left--;
            act_if.ready <= 1'b0;
        end else if (long_hold_req) begin
            long_hold_req = 1'b0;
            hold_left     = 400;
            act_if.ready <= 1'b0;
        end else begin
            if (stretch_left == 0) begin
                stretch_left = $urandom_range(20, 80);
                choppy       = ~choppy;
            end
            stretch_left--;
            act_if.ready <= choppy ? ($urandom_range(0, 2) != 0) : 1'b1;
        end
    end

    always @(posedge i_clk) begin : monitor
        t_in  r;
        t_res acts [$];
        t_res want;
        if (i_rst_n) begin
            idle_cycles++;
            if (req_if.valid && req_if.ready) begin
                idle_cycles = 0;
                r = request_queue.pop_front();
                parse_request(dut_view, r, acts);
                foreach (acts[i]) queue_action(expected_actions, acts[i]);
                req_taken = 1'b1;
            end
            if (act_if.valid && act_if.ready) begin
                idle_cycles = 0;
                if (expected_actions.size() == 0) begin
                    $error("unexpected action %0d", act_if.action);
                    errors++;
                end else begin
                    want = expected_actions.pop_front();
                    if (act_if.action !== want.action) begin
                        $error("action: expected %0d, got %0d", want.action, act_if.action);
                        errors++;
                    end
                    if (act_if.out_nonterminal !== want.out_nonterminal) begin
                        $error("out_nonterminal: expected %0d, got %0d",
                               want.out_nonterminal, act_if.out_nonterminal);
                        errors++;
                    end
                    if (act_if.out_production !== want.out_production) begin
                        $error("out_production: expected %0d, got %0d",
                               want.out_production, act_if.out_production);
                        errors++;
                    end
                    if (act_if.out_terminal !== want.out_terminal) begin
                        $error("out_terminal: expected %0d, got %0d",
                               want.out_terminal, act_if.out_terminal);
                        errors++;
                    end
                    if (act_if.last !== want.last) begin
                        $error("last: expected %0d, got %0d", want.last, act_if.last);
                        errors++;
                    end
                end
            end
            if (psel) idle_cycles = 0;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("Testbench completed WITH ERRORS");
                $finish;
            end
        end
    end

    initial begin
        int       added;
        int       phase;
        bit [4:0] cfg;
        errors        = 0;
        idle_cycles   = 0;
        req_taken     = 1'b0;
        long_hold_req = 1'b0;
        sender_pause  = 1'b0;
        added         = 0;
        phase         = 0;
        psel          = 1'b0;
        penable       = 1'b0;
        pwrite        = 1'b0;
        paddr         = '0;
        pwdata        = '0;
        req_if.valid             = 1'b0;
        req_if.opcode            = OP_TOKEN;
        req_if.token             = '0;
        req_if.nonterminal_index = '0;
        req_if.production_index  = '0;
        req_if.body_position     = '0;
        req_if.body_symbol       = '0;
        req_if.body_length       = '0;
        req_if.entry_valid       = 1'b0;
        act_if.ready             = 1'b0;
        for (int i = 0; i < 64; i++) prod_defined[i] = 1'b0;
        reset_parser(dut_view);
        reset_parser(plan_view);
        i_rst_n = 1'b0;
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;
        reg_write(5'd0);
        directed_part();
        added = request_queue.size();
        wait_idle();
        while (added < ITEM_TARGET) begin
            case (phase)
                0:       cfg = 5'd31;
                3:       cfg = 5'd0;
                default: cfg = 5'($urandom_range(0, 31));
            endcase
            reg_write(cfg);
            if (phase == 1) long_hold_req = 1'b1;
            build_grammar(added);
            run_sessions((ITEM_TARGET - added > 60) ? 60 : ITEM_TARGET - added, added);
            if (phase == 2) begin
                repeat (30) @(posedge i_clk);
                sender_pause = 1'b1;
                while (expected_actions.size() != 0 || req_if.valid) @(posedge i_clk);
                sender_pause = 1'b0;
            end
            wait_idle();
            phase++;
        end
        if (expected_actions.size() != 0) begin
            $error("%0d actions never arrived", expected_actions.size());
            errors++;
        end
        if (errors == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
